FILE: rtl/phi4_metropolis_site_update_defines.svh
// Assertion macros shared by the checker of the phi^4 site update block.
// Expects clk and arst_n in the scope of each use.
`ifndef PHI4_METROPOLIS_SITE_UPDATE_DEFINES_SVH
`define PHI4_METROPOLIS_SITE_UPDATE_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define PHI4_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define PHI4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/phi4msu_pkg.sv
`timescale 1ns / 1ps
// Shared widths and types of the phi^4 site update block.
// No dependencies.
package phi4msu_pkg;

	localparam int MODE_W     = 2;
	localparam int SITE_W     = 12;
	localparam int FIELD_W    = 16;
	localparam int THR_W      = 18;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// lattice extent after clamping; the width holds values up to 511
	localparam int EXT_W      = 9;
	// shared multiplier operand and product widths
	localparam int MUL_W      = 34;
	localparam int MUL_PW     = 2 * MUL_W;

	typedef struct packed {
		logic              done;
		logic [SITE_W-1:0] quo;
		logic [EXT_W-1:0]  rem;
	} div_res_t;

endpackage

FILE: rtl/phi4msu_ram.sv
`timescale 1ns / 1ps
// Field lattice storage: one write port, one read port with registered data.
// Uses phi4msu_pkg for the field width.
module phi4msu_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic [phi4msu_pkg::FIELD_W-1:0]  wdata,
	input  logic                             re,
	input  logic [AW-1:0]                    raddr,
	output logic [phi4msu_pkg::FIELD_W-1:0]  rdata
);
	import phi4msu_pkg::*;

	logic [FIELD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/phi4msu_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Uses phi4msu_pkg for operand widths.
module phi4msu_mul (
	input  logic                                   clk,
	input  logic signed [phi4msu_pkg::MUL_W-1:0]   op_a,
	input  logic signed [phi4msu_pkg::MUL_W-1:0]   op_b,
	output logic signed [phi4msu_pkg::MUL_PW-1:0]  prod
);
	import phi4msu_pkg::*;

	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end

endmodule

FILE: rtl/phi4msu_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle: site index into x and t.
// Uses phi4msu_pkg for widths and the result struct.
module phi4msu_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [phi4msu_pkg::SITE_W-1:0]  num,
	input  logic [phi4msu_pkg::EXT_W-1:0]   den,
	output phi4msu_pkg::div_res_t           res
);
	import phi4msu_pkg::*;

	localparam int CNT_W = $clog2(SITE_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SITE_W-1:0] num_q;
	logic [EXT_W-1:0]  rem_q;
	logic [EXT_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, num_q[SITE_W-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SITE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the quotient bits in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[SITE_W-2:0], ge};
			rem_q <= ge ? EXT_W'(trial - {1'b0, den}) : trial[EXT_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quo  = num_q;
	assign res.rem  = rem_q;

endmodule

FILE: rtl/phi4_metropolis_site_update.sv
`timescale 1ns / 1ps
// Top level of the phi^4 lattice site engine: sequencer, registers, datapath.
// Uses phi4msu_pkg, phi4msu_ram, phi4msu_mul and phi4msu_div.
//
//  channel  | direction | content
//  s_*      | in        | tuser: mode; tdata: site, load_value, proposal_factor,
//           |           |        accept_threshold
//  m_*      | out       | tuser: bad_site; tdata: accepted, field_value,
//           |           |        spin_positive, spin_change, field_change
//  cfg_*    | in        | register writes, index 0..4
//
// One item at a time: s_tready is high only while the sequencer is idle.
// A trial passes idle, check, the divider (site coordinates), 5 reads on the lattice
// read port, 8 shared products and done. A load and a bad site pass idle, check and
// done; a read passes idle, check, the lattice read and done.
// A finished result waits in the output register; the next item is taken
// meanwhile. The lattice memory has no reset and must be loaded before use.
module phi4_metropolis_site_update #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [11:0] site, [27:12] load_value, [43:28] proposal_factor,
	// [61:44] accept_threshold
	input  logic [phi4msu_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] mode
	input  logic [phi4msu_pkg::MODE_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] accepted, [16:1] field_value, [17] spin_positive,
	// [20:18] spin_change, [37:21] field_change
	output logic [phi4msu_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [0] bad_site
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [phi4msu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [phi4msu_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import phi4msu_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int ADDR_W = 18;
	localparam int ACC_W  = 82;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRIAL = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_QUARTIC = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;

	localparam logic [3:0] OP_STEP   = 4'd0;
	localparam logic [3:0] OP_A2     = 4'd1;
	localparam logic [3:0] OP_B2     = 4'd2;
	localparam logic [3:0] OP_SUM    = 4'd3;
	localparam logic [3:0] OP_QUAD   = 4'd4;
	localparam logic [3:0] OP_MASS   = 4'd5;
	localparam logic [3:0] OP_LO     = 4'd6;
	localparam logic [3:0] OP_HI     = 4'd7;
	localparam logic [3:0] OP_KIN    = 4'd8;
	localparam logic [3:0] OP_ADDK   = 4'd9;
	localparam logic [3:0] OP_DECIDE = 4'd10;

	localparam logic [2:0] RD_SITE  = 3'd0;
	localparam logic [2:0] RD_LEFT  = 3'd1;
	localparam logic [2:0] RD_RIGHT = 3'd2;
	localparam logic [2:0] RD_UP    = 3'd3;
	localparam logic [2:0] RD_DOWN  = 3'd4;
	localparam logic [2:0] RD_END   = 3'd5;

	localparam logic [15:0] QUARTIC_RST = 16'd4096;
	localparam logic [14:0] STEP_RST    = 15'd4096;
	localparam logic [6:0]  EXTENT_RST  = 7'd64;
	localparam logic [6:0]  EXTENT_MIN  = 7'd2;
	localparam logic [FIELD_W-1:0] FIELD_MAX = 16'h7FFF;
	localparam logic [FIELD_W-1:0] FIELD_MIN = 16'h8000;
	localparam logic [2:0] SPIN_UP   = 3'b010;
	localparam logic [2:0] SPIN_DOWN = 3'b110;

	// configuration
	logic [15:0]        lambda_q;
	logic [15:0]        mass_q;
	logic [14:0]        step_q;
	logic [6:0]         wcfg_q;
	logic [6:0]         hcfg_q;
	logic [EXT_W-1:0]   w_eff;
	logic [EXT_W-1:0]   h_eff;
	logic [ADDR_W-1:0]  wh;

	// item and sequencer
	logic [2:0]         state_q;
	logic [2:0]         rcnt_q;
	logic [3:0]         op_q;
	logic [MODE_W-1:0]  mode_q;
	logic [SITE_W-1:0]  site_q;
	logic [FIELD_W-1:0] load_q;
	logic [FIELD_W-1:0] factor_q;
	logic [THR_W-1:0]   thr_q;
	logic [EXT_W-1:0]   x_q;
	logic [SITE_W-1:0]  t_q;

	// datapath
	logic [FIELD_W-1:0]      a_q;
	logic [FIELD_W-1:0]      b_q;
	logic [FIELD_W:0]        ab_q;
	logic [17:0]             nsum_q;
	logic [31:0]             aa_q;
	logic [32:0]             d2_q;
	logic [31:0]             s2_q;
	logic [65:0]             m_q;
	logic signed [ACC_W-1:0] acc_q;

	// results
	logic                    res_acc_q;
	logic [FIELD_W-1:0]      res_val_q;
	logic [2:0]              res_dspin_q;
	logic [FIELD_W:0]        res_dfield_q;
	logic                    res_bad_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;
	logic                    m_tuser_q;

	// instance wiring
	logic                    div_start;
	div_res_t                div_res;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [FIELD_W-1:0]      mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;
	logic [FIELD_W-1:0]      mem_rdata;
	logic signed [MUL_W-1:0] op_a;
	logic signed [MUL_W-1:0] op_b;
	logic signed [MUL_PW-1:0] prod;

	// combinational helpers
	logic                    bad_now;
	logic [ADDR_W-1:0]       s_ext;
	logic [ADDR_W-1:0]       w_ext;
	logic [ADDR_W-1:0]       x_ext;
	logic [ADDR_W-1:0]       rd_addr;
	logic [16:0]             p_step;
	logic [17:0]             b_sum;
	logic [FIELD_W-1:0]      b_sat;
	logic [32:0]             d2_now;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] thr_ext;
	logic                    accept_now;
	logic                    a_pos;
	logic                    b_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= QUARTIC_RST;
			mass_q   <= '0;
			step_q   <= STEP_RST;
			wcfg_q   <= EXTENT_RST;
			hcfg_q   <= EXTENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUARTIC: lambda_q <= cfg_data;
				REG_MASS:    mass_q   <= cfg_data;
				REG_STEP:    step_q   <= cfg_data[14:0];
				REG_WIDTH:   wcfg_q   <= cfg_data[6:0];
				REG_HEIGHT:  hcfg_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// clamp extents into [2, MAX]
	always_comb begin
		if (wcfg_q < EXTENT_MIN) begin
			w_eff = EXT_W'(EXTENT_MIN);
		end else if (EXT_W'(wcfg_q) > EXT_W'(MAX_WIDTH)) begin
			w_eff = EXT_W'(MAX_WIDTH);
		end else begin
			w_eff = EXT_W'(wcfg_q);
		end
		if (hcfg_q < EXTENT_MIN) begin
			h_eff = EXT_W'(EXTENT_MIN);
		end else if (EXT_W'(hcfg_q) > EXT_W'(MAX_HEIGHT)) begin
			h_eff = EXT_W'(MAX_HEIGHT);
		end else begin
			h_eff = EXT_W'(hcfg_q);
		end
	end

	assign wh      = ADDR_W'(w_eff) * ADDR_W'(h_eff);
	assign bad_now = ADDR_W'(site_q) >= wh;
	assign s_ext   = ADDR_W'(site_q);
	assign w_ext   = ADDR_W'(w_eff);
	assign x_ext   = ADDR_W'(x_q);

	// periodic neighbor addresses
	always_comb begin
		case (rcnt_q)
			RD_LEFT:  rd_addr = (x_q == '0) ? s_ext + w_ext - 1'b1 : s_ext - 1'b1;
			RD_RIGHT: rd_addr = (x_q == w_eff - 1'b1) ? s_ext - w_ext + 1'b1
			                                          : s_ext + 1'b1;
			RD_UP:    rd_addr = (t_q == SITE_W'(h_eff - 1'b1)) ? x_ext : s_ext + w_ext;
			RD_DOWN:  rd_addr = (t_q == '0) ? s_ext + wh - w_ext : s_ext - w_ext;
			default:  rd_addr = s_ext;
		endcase
	end

	assign mem_re    = (state_q == ST_RD) && (rcnt_q != RD_END);
	assign mem_raddr = rd_addr[AW-1:0];

	// proposal: arithmetic shift of step times factor, then saturate
	assign p_step = prod[31:15];
	assign b_sum  = {{2{a_q[FIELD_W-1]}}, a_q} + {p_step[16], p_step};
	always_comb begin
		if (!b_sum[17] && (b_sum[16:15] != 2'b00)) begin
			b_sat = FIELD_MAX;
		end else if (b_sum[17] && (b_sum[16:15] != 2'b11)) begin
			b_sat = FIELD_MIN;
		end else begin
			b_sat = b_sum[FIELD_W-1:0];
		end
	end

	assign d2_now   = {1'b0, prod[31:0]} - {1'b0, aa_q};
	assign prod_ext = {{(ACC_W-MUL_PW){prod[MUL_PW-1]}}, prod};
	assign thr_ext  = $signed(ACC_W'(thr_q) << 50);
	assign accept_now = acc_q < thr_ext;
	assign a_pos    = !a_q[FIELD_W-1] && (a_q != '0);
	assign b_pos    = !b_q[FIELD_W-1] && (b_q != '0);

	// operand select of the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_MUL) begin
			case (op_q)
				OP_STEP: begin
					op_a = $signed({19'b0, step_q});
					op_b = $signed({{18{factor_q[15]}}, factor_q});
				end
				OP_A2: begin
					op_a = $signed({{18{a_q[15]}}, a_q});
					op_b = $signed({{18{a_q[15]}}, a_q});
				end
				OP_B2: begin
					op_a = $signed({{18{b_q[15]}}, b_q});
					op_b = $signed({{18{b_q[15]}}, b_q});
				end
				OP_QUAD: begin
					op_a = $signed({d2_q[32], d2_q});
					op_b = $signed({2'b0, s2_q});
				end
				OP_MASS: begin
					op_a = $signed({{18{mass_q[15]}}, mass_q});
					op_b = $signed({d2_q[32], d2_q});
				end
				OP_LO: begin
					op_a = $signed({2'b0, m_q[31:0]});
					op_b = $signed({18'b0, lambda_q});
				end
				OP_HI: begin
					op_a = $signed(m_q[65:32]);
					op_b = $signed({18'b0, lambda_q});
				end
				OP_KIN: begin
					op_a = $signed({{17{ab_q[16]}}, ab_q});
					op_b = $signed({{16{nsum_q[17]}}, nsum_q});
				end
				default: ;
			endcase
		end
	end

	assign div_start = (state_q == ST_CHK) && !bad_now && (mode_q == MODE_TRIAL);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = load_q;
		if ((state_q == ST_CHK) && !bad_now && (mode_q == MODE_LOAD)) begin
			mem_we = 1'b1;
		end else if ((state_q == ST_MUL) && (op_q == OP_DECIDE) && accept_now) begin
			mem_we    = 1'b1;
			mem_wdata = b_q;
		end
	end
	assign mem_waddr = AW'(site_q);

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rcnt_q     <= '0;
			op_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (bad_now || (mode_q == MODE_LOAD)) begin
						state_q <= ST_DONE;
					end else if (mode_q == MODE_TRIAL) begin
						state_q <= ST_DIV;
					end else begin
						rcnt_q  <= RD_SITE;
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						rcnt_q  <= RD_SITE;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					rcnt_q <= rcnt_q + 1'b1;
					if ((rcnt_q == RD_LEFT) && (mode_q != MODE_TRIAL)) begin
						state_q <= ST_DONE;
					end else if (rcnt_q == RD_END) begin
						op_q    <= OP_STEP;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					op_q <= op_q + 1'b1;
					if (op_q == OP_DECIDE) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			mode_q   <= s_tuser;
			site_q   <= s_tdata[11:0];
			load_q   <= s_tdata[27:12];
			factor_q <= s_tdata[43:28];
			thr_q    <= s_tdata[61:44];
		end
		if ((state_q == ST_DIV) && div_res.done) begin
			x_q <= div_res.rem;
			t_q <= div_res.quo;
		end
		if (state_q == ST_CHK) begin
			res_acc_q    <= 1'b0;
			res_val_q    <= bad_now ? '0 : load_q;
			res_dspin_q  <= '0;
			res_dfield_q <= '0;
			res_bad_q    <= bad_now;
			nsum_q       <= '0;
		end
		if (state_q == ST_RD) begin
			if (rcnt_q == RD_LEFT) begin
				a_q       <= mem_rdata;
				res_val_q <= mem_rdata;
			end else if (rcnt_q != RD_SITE) begin
				nsum_q <= nsum_q + {{2{mem_rdata[15]}}, mem_rdata};
			end
		end
		if (state_q == ST_MUL) begin
			case (op_q)
				OP_A2: begin
					b_q  <= b_sat;
					ab_q <= {a_q[15], a_q} - {b_sat[15], b_sat};
				end
				OP_B2:   aa_q <= prod[31:0];
				OP_SUM: begin
					d2_q  <= d2_now;
					s2_q  <= prod[31:0] + aa_q;
					acc_q <= $signed({{(ACC_W-33){d2_now[32]}}, d2_now}) <<< 39;
				end
				OP_MASS: m_q   <= prod[65:0];
				OP_LO:   acc_q <= acc_q + (prod_ext <<< 25);
				OP_HI:   acc_q <= acc_q + prod_ext;
				OP_KIN:  acc_q <= acc_q + (prod_ext <<< 32);
				OP_ADDK: acc_q <= acc_q + (prod_ext <<< 38);
				OP_DECIDE: begin
					if (accept_now) begin
						res_acc_q    <= 1'b1;
						res_val_q    <= b_q;
						res_dspin_q  <= (a_pos == b_pos) ? 3'b000
						              : (b_pos ? SPIN_UP : SPIN_DOWN);
						res_dfield_q <= {b_q[15], b_q} - {a_q[15], a_q};
					end
				end
				default: ;
			endcase
		end
		if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {2'b00, res_dfield_q, res_dspin_q,
			              (!res_val_q[15] && (res_val_q != '0)), res_val_q, res_acc_q};
			m_tuser_q <= res_bad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	phi4msu_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	phi4msu_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	phi4msu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (site_q),
		.den    (w_eff),
		.res    (div_res)
	);

endmodule

FILE: rtl/phi4msu_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the phi^4 site update block, bound to its top level.
// Uses phi4_metropolis_site_update_defines.svh and phi4msu_pkg.
`include "phi4_metropolis_site_update_defines.svh"

module phi4msu_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [phi4msu_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                                m_tuser
);
	import phi4msu_pkg::*;

	`PHI4_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`PHI4_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")
	`PHI4_ASSERT_SAME(a_bad_clean, m_tvalid && m_tuser, m_tdata == '0, "bad site result carries data")
	`PHI4_ASSERT_SAME(a_reject_zero, m_tvalid && !m_tdata[0], m_tdata[37:18] == '0, "change reported without acceptance")

endmodule

bind phi4_metropolis_site_update phi4msu_checker u_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for phi4_metropolis_site_update: loads, reads and Metropolis trials
// over several lattice settings, each result compared with an in-bench lattice predictor.
// Depends on phi4msu_pkg and the block's RTL.
module tb;
	import phi4msu_pkg::*;

	typedef enum logic [1:0] {MODE_LOAD, MODE_TRIAL, MODE_READ, MODE_READ_ALT} site_mode_t;
	typedef enum logic [2:0] {REG_QUARTIC, REG_MASS, REG_STEP, REG_WIDTH, REG_HEIGHT} cfg_reg_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] field_value;
		logic        spin_positive;
		logic [2:0]  spin_change;
		logic [16:0] field_change;
		logic        bad_site;
	} site_result_t;

	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [MODE_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	phi4_metropolis_site_update DUT (.*);

	// predictor state: lattice contents and register copies
	shortint lattice [4096];
	bit written [4096];
	int quartic = 4096, mass = 0, step = 4096, width_reg = 64, height_reg = 64;

	site_result_t pending_results[$];
	int failures = 0;
	int n_results = 0, n_accepted = 0, n_trials = 0, n_bad = 0;
	int burst_left = 0;
	int stall_phase = 0;

	initial forever #4 clk = ~clk;

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	function automatic int ext_w();
		return width_reg < 2 ? 2 : (width_reg > 64 ? 64 : width_reg);
	endfunction

	function automatic int ext_h();
		return height_reg < 2 ? 2 : (height_reg > 64 ? 64 : height_reg);
	endfunction

	// site and its four periodic neighbours all hold loaded values
	function automatic bit trial_safe(int site);
		int w, h, x, t;
		w = ext_w();
		h = ext_h();
		x = site % w;
		t = site / w;
		return written[site] && written[(x + 1) % w + w * t] && written[(x + w - 1) % w + w * t]
			&& written[x + w * ((t + 1) % h)] && written[x + w * ((t + h - 1) % h)];
	endfunction

	task automatic predict_site_update(input logic [1:0] mode, input int site,
			input logic signed [15:0] load, input logic signed [15:0] factor,
			input logic [17:0] thr);
		int w, h, x, t;
		longint a, b, p, nsum, d2, s2, so, sn;
		logic signed [127:0] term, energy, margin;
		site_result_t r;
		w = ext_w();
		h = ext_h();
		r = '0;
		if (site >= w * h) begin
			r.bad_site = 1'b1;
			n_bad++;
			pending_results.push_back(r);
			return;
		end
		if (mode == MODE_LOAD) begin
			lattice[site] = load;
			written[site] = 1'b1;
			r.field_value = load;
		end else if (mode == MODE_TRIAL) begin
			n_trials++;
			x = site % w;
			t = site / w;
			a = lattice[site];
			nsum = longint'(lattice[(x + 1) % w + w * t]) + lattice[(x + w - 1) % w + w * t]
				+ lattice[x + w * ((t + 1) % h)] + lattice[x + w * ((t + h - 1) % h)];
			p = (longint'(step) * longint'(factor)) >>> 15;
			b = a + p;
			if (b > 32767) b = 32767;
			if (b < -32768) b = -32768;
			d2 = b * b - a * a;
			s2 = b * b + a * a;
			term = d2 * s2;
			energy = term * $signed({112'd0, quartic[15:0]});
			term = longint'(mass) * d2;
			energy = energy + (term <<< 25);
			term = d2;
			energy = energy + (term <<< 39);
			term = (a - b) * nsum;
			energy = energy + (term <<< 38);
			margin = $signed({110'd0, thr});
			margin = (margin <<< 50) - energy;
			r.field_value = a[15:0];
			if (margin > 0) begin
				so = a > 0 ? 1 : -1;
				sn = b > 0 ? 1 : -1;
				lattice[site] = b[15:0];
				r.accepted = 1'b1;
				r.field_value = b[15:0];
				r.spin_change = 3'(sn - so);
				r.field_change = 17'(b - a);
				n_accepted++;
			end
		end else begin
			r.field_value = lattice[site];
		end
		r.spin_positive = $signed(r.field_value) > 0;
		pending_results.push_back(r);
	endtask

	// sender works in bursts; valid stays high inside a burst
	task automatic send_site_item(input logic [1:0] mode, input int site,
			input logic [15:0] load, input logic [15:0] factor, input logic [17:0] thr);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {2'b00, thr, factor, load, site[11:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_site_update(mode, site, load, factor, thr);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_QUARTIC: quartic = value & 16'hFFFF;
			REG_MASS:    mass = int'($signed(value[15:0]));
			REG_STEP:    step = value & 16'h7FFF;
			REG_WIDTH:   width_reg = value & 7'h7F;
			REG_HEIGHT:  height_reg = value & 7'h7F;
			default: ;
		endcase
	endtask

	task automatic apply_setting(int q, int m, int s, int w, int h);
		drain_results();
		write_reg(REG_QUARTIC, q);
		write_reg(REG_MASS, m);
		write_reg(REG_STEP, s);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		@(posedge clk);
	endtask

	// directed: tiny lattice, field extremes, every mode, saturation, bad sites
	task automatic test_directed();
		int k;
		logic [15:0] extremes [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000};
		apply_setting(4096, 0, 32767, 3, 2);
		for (k = 0; k < 6; k++) send_site_item(MODE_LOAD, k, extremes[k], 0, 0);
		send_site_item(MODE_TRIAL, 0, 0, 16'h7FFF, 18'h3FFFF);
		send_site_item(MODE_TRIAL, 1, 0, 16'h8000, 18'h3FFFF);
		send_site_item(MODE_TRIAL, 2, 0, 16'h0000, 18'h00000);
		send_site_item(MODE_TRIAL, 3, 0, 16'h8000, 18'h3FFFF);
		send_site_item(MODE_TRIAL, 4, 0, 16'h7FFF, 18'h00000);
		send_site_item(MODE_TRIAL, 5, 0, 16'h8000, 18'h00001);
		send_site_item(MODE_READ, 0, 0, 0, 0);
		send_site_item(MODE_READ_ALT, 1, 0, 0, 0);
		send_site_item(MODE_READ, 6, 0, 0, 0);
		send_site_item(MODE_LOAD, 4095, 16'h1234, 0, 0);
		send_site_item(MODE_TRIAL, 7, 0, 16'h4000, 18'h3FFFF);
	endtask

	task automatic test_random_phase(int n_items, int q, int m, int s, int w, int h);
		int i, r, site, cells, span;
		logic [1:0] mode;
		logic [15:0] load;
		apply_setting(q, m, s, w, h);
		cells = ext_w() * ext_h();
		span = cells > 192 ? 192 : cells;
		for (i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			site = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cells - 1)
				: $urandom_range(0, span - 1);
			mode = r < 20 ? MODE_LOAD : (r < 32 ? ($urandom_range(0, 1) ? MODE_READ : MODE_READ_ALT)
				: MODE_TRIAL);
			if (r >= 94 && cells < 4096) site = $urandom_range(cells, 4095);
			else if (mode == MODE_TRIAL && !trial_safe(site)) mode = MODE_LOAD;
			else if (mode != MODE_LOAD && !written[site]) mode = MODE_LOAD;
			load = ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($signed($urandom_range(0, 16384)) - 8192);
			send_site_item(mode, site, load, 16'($urandom), 18'($urandom));
		end
	endtask

	// receiver: alternate between free-running and stalled stretches
	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1) % 300;
		if (stall_phase < 100) m_tready <= 1'b1;
		else if (stall_phase < 200) m_tready <= $urandom_range(0, 3) != 0;
		else m_tready <= $urandom_range(0, 2) == 0;
	end

	always @(posedge clk) begin
		site_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[16:1], m_tdata[17], m_tdata[20:18], m_tdata[37:21], m_tuser};
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result transfer with no pending expectation");
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (got.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
					failures++;
				end
				if (got.field_value !== want.field_value) begin
					$error("field_value: expected %0d, got %0d",
						$signed(want.field_value), $signed(got.field_value));
					failures++;
				end
				if (got.spin_positive !== want.spin_positive) begin
					$error("spin_positive: expected %0d, got %0d",
						want.spin_positive, got.spin_positive);
					failures++;
				end
				if (got.spin_change !== want.spin_change) begin
					$error("spin_change: expected %0d, got %0d",
						$signed(want.spin_change), $signed(got.spin_change));
					failures++;
				end
				if (got.field_change !== want.field_change) begin
					$error("field_change: expected %0d, got %0d",
						$signed(want.field_change), $signed(got.field_change));
					failures++;
				end
				if (got.bad_site !== want.bad_site) begin
					$error("bad_site: expected %0d, got %0d", want.bad_site, got.bad_site);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random_phase(480, 4096, 0, 4096, 64, 64);
		test_random_phase(250, 4096, 0, 4096, 2, 2);
		test_random_phase(200, 0, -32768, 32767, 0, 127);
		test_random_phase(200, 65535, 32767, 0, 127, 0);
		test_random_phase(250, 8192, -4096, 2048, 7, 5);
		test_random_phase(200, 1024, 12000, 16384, 16, 3);
		test_random_phase(150, $urandom_range(0, 65535), $signed(16'($urandom)),
			$urandom_range(0, 32767), $urandom_range(2, 64), $urandom_range(2, 64));
		drain_results();
		$display("Covered %0d results: %0d trials (%0d accepted), %0d bad-site items.",
			n_results, n_trials, n_accepted, n_bad);
		if (failures == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/phi4msu_pkg.sv
rtl/phi4msu_ram.sv
rtl/phi4msu_mul.sv
rtl/phi4msu_div.sv
rtl/phi4_metropolis_site_update.sv
rtl/phi4msu_checker.sv
tb/tb.sv
